// ===== rtl/ple_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, sizes and codes for the positional list engine.
package ple_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 9;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_FIND = 2'd3
  } cell_op_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    cell_op_t               op;
    logic [IDX_W-1:0]       slot;
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]       count;
  } cell_ctl_t;

endpackage

// ===== rtl/ple_cell.sv =====
`timescale 1ns / 1ps
// One list slot: holds an entry, shifts with its neighbors, compares for find.
module ple_cell import ple_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cell_ctl_t               ctl,
  input  logic [IDX_W-1:0]        cell_index,
  input  logic signed [VAL_W-1:0] left_i,
  input  logic signed [VAL_W-1:0] right_i,
  output logic signed [VAL_W-1:0] data_o,
  output logic                    match_o
);

  logic signed [VAL_W-1:0] data_r, data_nxt;
  logic                    match_r, match_nxt;
  logic                    live;

  assign live = CNT_W'(cell_index) < ctl.count;

  always_comb begin
    data_nxt  = data_r;
    match_nxt = match_r;
    unique case (ctl.op)
      CELL_HOLD: ;
      CELL_INS: begin
        // open a gap at the slot: later entries take their left neighbor
        if (cell_index > ctl.slot) begin
          data_nxt = left_i;
        end else if (cell_index == ctl.slot) begin
          data_nxt = ctl.value;
        end
      end
      CELL_DEL: begin
        if (cell_index >= ctl.slot) begin
          data_nxt = right_i;
        end
      end
      CELL_FIND: begin
        match_nxt = live && (data_r == ctl.value);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign data_o  = data_r;
  assign match_o = match_r;

endmodule

// ===== rtl/ple_first_match.sv =====
`timescale 1ns / 1ps
// Two-stage registered find-first over the cell match flags.
module ple_first_match import ple_pkg::*; (
  input  logic                clk,
  input  logic [CAPACITY-1:0] match_i,
  output logic                hit_o,
  output logic [IDX_W-1:0]    index_o
);

  localparam int GRP    = 16;
  localparam int GRP_W  = 4;
  localparam int NGRP   = (CAPACITY + GRP - 1) / GRP;
  localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PAD_W  = NGRP * GRP;

  logic [PAD_W-1:0]       match_pad;
  logic [NGRP-1:0]        grp_hit_r, grp_hit_nxt;
  logic [GRP_W-1:0]       grp_sub_r [NGRP];
  logic [GRP_W-1:0]       grp_sub_nxt [NGRP];
  logic                   hit_r, hit_nxt;
  logic [IDX_W-1:0]       index_r, index_nxt;

  assign match_pad = PAD_W'(match_i);

  // stage one: first set flag inside each group of sixteen
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit_nxt[g] = |match_pad[g*GRP +: GRP];
      grp_sub_nxt[g] = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
        if (match_pad[g*GRP + b]) begin
          grp_sub_nxt[g] = GRP_W'(b);
        end
      end
    end
  end

  // stage two: first group with a hit
  always_comb begin
    hit_nxt   = |grp_hit_r;
    index_nxt = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_hit_r[g]) begin
        index_nxt = IDX_W'({NGRP_W'(g), grp_sub_r[g]});
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_hit_r <= grp_hit_nxt;
    grp_sub_r <= grp_sub_nxt;
    hit_r     <= hit_nxt;
    index_r   <= index_nxt;
  end

  assign hit_o   = hit_r;
  assign index_o = index_r;

endmodule

// ===== rtl/positional_list_engine.sv =====
`timescale 1ns / 1ps
// Top level: command control, cell chain, match encoder and result register.
//
//  channel | direction | ports
//  --------+-----------+------------------------------------------------------
//  in      | request   | in_valid in_ready in_command in_position in_value
//  out     | result    | out_valid out_ready out_status out_found_position
//          |           | out_length out_empty
//
// Insert and delete shift the cells in parallel at the accept edge; clear only
// resets the count. The result then enters the output register.
// Find steps: cell compare, two find-first encoder stages, result.
// One request is in work at a time; a new one is taken while the previous
// result still waits in the output register. A stalled result holds the block.
// Synchronous active-low reset empties the list; entry storage is not cleared.
module positional_list_engine import ple_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_command,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic [8:0]              out_found_position,
  output logic [8:0]              out_length,
  output logic                    out_empty
);

  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FIND1 = 5'b00010,
    S_FIND2 = 5'b00100,
    S_FIND3 = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  status_t           pend_status_r, pend_status_nxt;
  logic [8:0]        pend_found_r, pend_found_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [8:0]        out_found_r, out_found_nxt;
  logic [8:0]        out_len_r, out_len_nxt;
  logic              out_empty_r, out_empty_nxt;

  cmd_t              cmd;
  logic              accept;
  logic              out_free;
  logic [CMP_W-1:0]  pos_ext, cnt_ext;
  logic              ins_bad, del_bad, list_full;
  cell_ctl_t         ctl;

  logic signed [VAL_W-1:0] cell_data [CAPACITY];
  logic signed [VAL_W-1:0] left_w    [CAPACITY];
  logic signed [VAL_W-1:0] right_w   [CAPACITY];
  logic [CAPACITY-1:0]     match_w;
  logic                    fm_hit;
  logic [IDX_W-1:0]        fm_index;

  assign cmd      = cmd_t'(in_command);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign pos_ext   = CMP_W'(in_position);
  assign cnt_ext   = CMP_W'(count_r);
  assign ins_bad   = (pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1));
  assign del_bad   = (pos_ext == '0) || (pos_ext > cnt_ext);
  assign list_full = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    ctl.op    = CELL_HOLD;
    ctl.slot  = IDX_W'(in_position - POS_W'(1));
    ctl.value = in_value;
    ctl.count = count_r;
    if (accept) begin
      unique case (cmd)
        CMD_INSERT: if (!ins_bad && !list_full) ctl.op = CELL_INS;
        CMD_DELETE: if (!del_bad) ctl.op = CELL_DEL;
        CMD_FIND:   ctl.op = CELL_FIND;
        CMD_CLEAR:  ctl.op = CELL_HOLD;
        default:    ctl.op = CELL_HOLD;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = cell_data[i];
    end else begin : g_left
      assign left_w[i] = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w[i] = cell_data[i];
    end else begin : g_right
      assign right_w[i] = cell_data[i+1];
    end

    ple_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .cell_index (IDX_W'(i)),
      .left_i     (left_w[i]),
      .right_i    (right_w[i]),
      .data_o     (cell_data[i]),
      .match_o    (match_w[i])
    );
  end

  ple_first_match u_first_match (
    .clk     (clk),
    .match_i (match_w),
    .hit_o   (fm_hit),
    .index_o (fm_index)
  );

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    pend_status_nxt = pend_status_r;
    pend_found_nxt  = pend_found_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_found_nxt   = out_found_r;
    out_len_nxt     = out_len_r;
    out_empty_nxt   = out_empty_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          pend_found_nxt = '0;
          state_nxt      = S_DONE;
          unique case (cmd)
            CMD_INSERT: begin
              if (ins_bad) begin
                pend_status_nxt = ST_RANGE;
              end else if (list_full) begin
                pend_status_nxt = ST_FULL;
              end else begin
                pend_status_nxt = ST_OK;
                count_nxt       = count_r + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              if (del_bad) begin
                pend_status_nxt = ST_RANGE;
              end else begin
                pend_status_nxt = ST_OK;
                count_nxt       = count_r - CNT_W'(1);
              end
            end
            CMD_FIND: begin
              state_nxt = S_FIND1;
            end
            CMD_CLEAR: begin
              pend_status_nxt = ST_OK;
              count_nxt       = '0;
            end
            default: ;
          endcase
        end
      end
      S_FIND1: state_nxt = S_FIND2;
      S_FIND2: state_nxt = S_FIND3;
      S_FIND3: begin
        if (fm_hit) begin
          pend_status_nxt = ST_OK;
          pend_found_nxt  = 9'(CNT_W'(fm_index) + CNT_W'(1));
        end else begin
          pend_status_nxt = ST_MISS;
          pend_found_nxt  = '0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_found_nxt  = pend_found_r;
          out_len_nxt    = 9'(count_r);
          out_empty_nxt  = (count_r == '0);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pend_found_r  <= pend_found_nxt;
    out_status_r  <= out_status_nxt;
    out_found_r   <= out_found_nxt;
    out_len_r     <= out_len_nxt;
    out_empty_r   <= out_empty_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_length         = out_len_r;
  assign out_empty          = out_empty_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == CELL_INS) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the list");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_empty_r == (out_len_r == '0)))
    else $error("empty flag disagrees with length");

  a_find_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND3) |=> ((pend_status_r == ST_OK) == (pend_found_r != '0)))
    else $error("find status disagrees with position");

endmodule

// ===== tb/positional_list_engine_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the positional list engine: queued random and directed requests.
module positional_list_engine_tb;
  import ple_pkg::*;

  typedef struct {
    cmd_t                    cmd;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
  } list_request_t;

  typedef struct {
    status_t    status;
    logic [8:0] found;
    logic [8:0] length;
    logic       empty;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_command = 2'd0;
  logic [POS_W-1:0]        in_position = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              out_status;
  logic [8:0]              out_found_position;
  logic [8:0]              out_length;
  logic                    out_empty;

  list_request_t           pending_requests[$];
  list_result_t            expected_results[$];
  logic signed [VAL_W-1:0] list_contents[$];
  logic signed [VAL_W-1:0] value_pool[8];
  int                      planned_length;
  int                      mismatch_count;
  int                      burst_left;
  int                      gap_left;
  int                      stall_mode;
  int                      stall_left;
  int                      stall_phase;
  list_request_t           next_req;
  list_result_t            want;

  positional_list_engine dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_found_position(out_found_position),
    .out_length        (out_length),
    .out_empty         (out_empty)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Update the list as the block must, and record the result it owes.
  task automatic apply_list_request(input cmd_t cmd, input logic [POS_W-1:0] pos,
                                    input logic signed [VAL_W-1:0] val);
    list_result_t r;
    int           len;
    int           p;
    len = list_contents.size();
    p = int'(pos);
    r.status = ST_OK;
    r.found = '0;
    case (cmd)
      CMD_INSERT: begin
        if (p < 1 || p > len + 1) r.status = ST_RANGE;
        else if (len >= CAPACITY) r.status = ST_FULL;
        else list_contents.insert(p - 1, val);
      end
      CMD_DELETE: begin
        if (p < 1 || p > len) r.status = ST_RANGE;
        else list_contents.delete(p - 1);
      end
      CMD_FIND: begin
        r.status = ST_MISS;
        for (int k = 0; k < len; k++) begin
          if (r.status == ST_MISS && list_contents[k] == val) begin
            r.status = ST_OK;
            r.found = 9'(k + 1);
          end
        end
      end
      default: list_contents.delete();
    endcase
    r.length = 9'(list_contents.size());
    r.empty = (list_contents.size() == 0);
    expected_results.push_back(r);
  endtask

  // Queue a request and track the length it leaves, so later positions can aim in range.
  task automatic plan_request(input cmd_t cmd, input int pos, input logic signed [VAL_W-1:0] val);
    list_request_t req;
    req.cmd = cmd;
    req.pos = POS_W'(pos);
    req.val = val;
    pending_requests.push_back(req);
    case (cmd)
      CMD_INSERT: if (pos >= 1 && pos <= planned_length + 1 && planned_length < CAPACITY)
        planned_length++;
      CMD_DELETE: if (pos >= 1 && pos <= planned_length) planned_length--;
      CMD_CLEAR:  planned_length = 0;
      default: ;
    endcase
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Mostly in range, with edges and noise mixed in.
  function automatic int pick_position(input int hi);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75 && hi > 0) return $urandom_range(1, hi);
    if (roll < 85) return 0;
    if (roll < 95) return (hi + 1 > 511) ? 511 : hi + 1;
    return $urandom_range(0, 511);
  endfunction

  task automatic plan_random_request();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 42) plan_request(CMD_INSERT, pick_position(planned_length + 1), pick_value());
    else if (roll < 72) plan_request(CMD_DELETE, pick_position(planned_length), pick_value());
    else if (roll < 98) plan_request(CMD_FIND, $urandom_range(0, 511), pick_value());
    else plan_request(CMD_CLEAR, $urandom_range(0, 511), $urandom);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_list_request(cmd_t'(in_command), in_position, in_value);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          next_req = pending_requests.pop_front();
          in_command <= next_req.cmd;
          in_position <= next_req.pos;
          in_value <= next_req.val;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                       : $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result and stall on a pattern that changes mode now and then.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_mode <= 0;
      stall_left <= 0;
      stall_phase <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, status %0d", out_status));
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_found_position !== want.found)
            report_mismatch($sformatf("found_position %0d, want %0d",
                                      out_found_position, want.found));
          if (out_length !== want.length)
            report_mismatch($sformatf("length %0d, want %0d",
                                      out_length, want.length));
          if (out_empty !== want.empty)
            report_mismatch($sformatf("empty %0b, want %0b", out_empty, want.empty));
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(20, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ((stall_phase % 8) < 3);
      endcase
    end
  end

  initial begin
    mismatch_count = 0;
    planned_length = 0;
    value_pool[0] = 32'sh7fffffff;
    value_pool[1] = 32'sh80000000;
    value_pool[2] = 0;
    value_pool[3] = -1;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

    // Directed: empty list, range edges, extremes, duplicates, clear.
    plan_request(CMD_CLEAR, 0, 0);
    plan_request(CMD_DELETE, 1, 0);
    plan_request(CMD_DELETE, 0, 0);
    plan_request(CMD_FIND, 0, 0);
    plan_request(CMD_INSERT, 0, 5);
    plan_request(CMD_INSERT, 2, 5);
    plan_request(CMD_INSERT, 1, 32'sh7fffffff);
    plan_request(CMD_INSERT, 2, 32'sh80000000);
    plan_request(CMD_INSERT, 1, -1);
    plan_request(CMD_INSERT, 511, 7);
    plan_request(CMD_INSERT, 3, 0);
    plan_request(CMD_INSERT, 2, -1);
    plan_request(CMD_FIND, 0, -1);
    plan_request(CMD_FIND, 511, 32'sh80000000);
    plan_request(CMD_FIND, 3, 123);
    plan_request(CMD_DELETE, 6, 0);
    plan_request(CMD_DELETE, 511, 0);
    plan_request(CMD_DELETE, 5, 0);
    plan_request(CMD_DELETE, 1, 0);
    plan_request(CMD_FIND, 0, -1);
    plan_request(CMD_INSERT, 4, 32'sh55aa55aa);
    plan_request(CMD_CLEAR, 511, -1);
    plan_request(CMD_FIND, 0, -1);
    plan_request(CMD_DELETE, 1, 0);

    // Random mix of short lists.
    repeat (250) plan_random_request();

    // Fill to capacity, probe the full list, then drain it.
    plan_request(CMD_CLEAR, 0, 0);
    while (planned_length < CAPACITY) begin
      if ($urandom_range(0, 9) == 0) plan_request(CMD_FIND, 0, pick_value());
      else if ($urandom_range(0, 29) == 0)
        plan_request(CMD_INSERT, planned_length + 2, pick_value());
      else plan_request(CMD_INSERT, $urandom_range(1, planned_length + 1), pick_value());
    end
    plan_request(CMD_INSERT, CAPACITY + 1, pick_value());
    plan_request(CMD_INSERT, 1, pick_value());
    plan_request(CMD_INSERT, CAPACITY + 2, pick_value());
    plan_request(CMD_INSERT, 511, pick_value());
    plan_request(CMD_FIND, 0, pick_value());
    plan_request(CMD_FIND, 0, $urandom);
    plan_request(CMD_DELETE, CAPACITY + 1, 0);
    plan_request(CMD_DELETE, CAPACITY, 0);
    plan_request(CMD_INSERT, CAPACITY, 32'sh80000000);
    plan_request(CMD_FIND, 0, 32'sh80000000);
    plan_request(CMD_INSERT, 0, 0);
    while (planned_length > 0) begin
      if ($urandom_range(0, 19) == 0)
        plan_request(CMD_INSERT, pick_position(planned_length + 1), pick_value());
      else if ($urandom_range(0, 5) == 0) plan_request(CMD_FIND, 0, pick_value());
      else plan_request(CMD_DELETE, pick_position(planned_length), 0);
    end
    repeat (100) plan_random_request();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_requests.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
